// ===== rtl/core/utf8_to_codepoint_decoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Shared property wrappers; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_CODEPOINT_DECODER_TOP_MACROS_SVH
`define UTF8_TO_CODEPOINT_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define U8DEC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8dec: same-cycle check failed");

// Next-cycle implication, disabled while reset is held
`define U8DEC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8dec: next-cycle check failed");

`endif

// ===== rtl/core/u8dec_pkg.sv =====
// ----------------------------------------------------------------------------
// u8dec_pkg
// Types, constants and the per-byte update function of the UTF-8 decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned PEND_W  = 2;
  // code point padded up to whole bytes on the output bus
  localparam int unsigned OUT_TDATA_W = ((CP_W + 7) / 8) * 8;

  localparam logic [CP_W-1:0] QMARK_CP = CP_W'(8'h3F);

  typedef struct packed {
    logic [PEND_W-1:0] pending;
    logic [CP_W-1:0]   partial;
  } dec_state_t;

  typedef struct packed {
    dec_state_t      nxt;
    logic            emit;
    logic [CP_W-1:0] cp;
  } dec_result_t;

  // One byte of decode: sequence continuation, ASCII, lead bytes, end of text
  function automatic dec_result_t dec_step(dec_state_t st, logic [BYTE_W-1:0] b,
                                           logic last);
    dec_result_t r;
    r.nxt  = st;
    r.emit = 1'b0;
    r.cp   = '0;
    if (st.pending != '0) begin
      r.nxt.partial = {st.partial[CP_W-7:0], b[5:0]};
      r.nxt.pending = st.pending - PEND_W'(1);
      if (st.pending == PEND_W'(1)) begin
        r.emit = 1'b1;
        r.cp   = {st.partial[CP_W-7:0], b[5:0]};
      end
    end else if (b[7] == 1'b0) begin
      r.emit = 1'b1;
      r.cp   = CP_W'(b);
    end else if (b[7:5] == 3'b110) begin
      r.nxt.partial = CP_W'(b[4:0]);
      r.nxt.pending = PEND_W'(1);
    end else if (b[7:4] == 4'b1110) begin
      r.nxt.partial = CP_W'(b[3:0]);
      r.nxt.pending = PEND_W'(2);
    end else if (b[7:3] == 5'b11110) begin
      r.nxt.partial = CP_W'(b[2:0]);
      r.nxt.pending = PEND_W'(3);
    end
    // stray continuation or invalid lead: dropped, state unchanged

    // end of text: truncated sequence reports '?', state starts over
    if (last) begin
      if (r.nxt.pending != '0) begin
        r.emit = 1'b1;
        r.cp   = QMARK_CP;
      end
      r.nxt = '0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/utf8_to_codepoint_decoder_top.sv =====
// The byte that completes a code point loads it into the output register, or into the skid entry if that is full.
// Throughput: one byte per cycle while in_tready is high; bytes that complete no code point give no beat.
// A two-entry output stage (register plus skid) keeps in_tready high while a beat waits.
// Reset (rst_n low, synchronous) clears the pending count, accumulator and output stage.
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder_top
// Streams UTF-8 bytes in and decoded code points out, one byte per beat.
// ----------------------------------------------------------------------------
module utf8_to_codepoint_decoder_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [u8dec_pkg::BYTE_W-1:0]        in_tdata,   // [7:0] text_byte
  input  logic                                in_tlast,   // final_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [u8dec_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [20:0] code_point, rest zero
  output logic                                out_tlast   // ends_text
);
  import u8dec_pkg::*;

  dec_state_t      state_r;
  dec_result_t     step;
  logic            in_beat;
  logic            out_pop;

  logic            out_valid_r, out_valid_nxt;
  logic [CP_W-1:0] out_cp_r, out_cp_nxt;
  logic            out_last_r, out_last_nxt;
  logic            skid_valid_r, skid_valid_nxt;
  logic [CP_W-1:0] skid_cp_r, skid_cp_nxt;
  logic            skid_last_r, skid_last_nxt;

  assign in_tready = !skid_valid_r;
  assign in_beat   = in_tvalid && in_tready;
  assign out_pop   = out_valid_r && out_tready;

  // per-byte decode
  always_comb begin
    step = dec_step(state_r, in_tdata, in_tlast);
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_beat) begin
      state_r <= step.nxt;
    end
  end

  // output register and skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_cp_nxt     = out_cp_r;
    out_last_nxt   = out_last_r;
    skid_valid_nxt = skid_valid_r;
    skid_cp_nxt    = skid_cp_r;
    skid_last_nxt  = skid_last_r;
    if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
    if (skid_valid_r && !out_valid_nxt) begin
      out_valid_nxt  = 1'b1;
      out_cp_nxt     = skid_cp_r;
      out_last_nxt   = skid_last_r;
      skid_valid_nxt = 1'b0;
    end
    if (in_beat && step.emit) begin
      if (!out_valid_nxt) begin
        out_valid_nxt = 1'b1;
        out_cp_nxt    = step.cp;
        out_last_nxt  = in_tlast;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_cp_nxt    = step.cp;
        skid_last_nxt  = in_tlast;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_cp_r    <= out_cp_nxt;
    out_last_r  <= out_last_nxt;
    skid_cp_r   <= skid_cp_nxt;
    skid_last_r <= skid_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_cp_r);
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/core/u8dec_checker.sv =====
// ----------------------------------------------------------------------------
// u8dec_checker
// Port-level checks of the UTF-8 decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "utf8_to_codepoint_decoder_top_macros.svh"

module u8dec_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [u8dec_pkg::BYTE_W-1:0]      in_tdata,   // [7:0] text_byte
  input logic                              in_tlast,   // final_byte
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [u8dec_pkg::OUT_TDATA_W-1:0] out_tdata,  // [20:0] code_point, rest zero
  input logic                              out_tlast   // ends_text
);
  import u8dec_pkg::*;

  logic in_seen;
  assign in_seen = in_tvalid || (in_tdata != '0) || in_tlast;

  // a stalled result beat holds its contents
  `U8DEC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                     out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // pad bits above the code point stay zero
  `U8DEC_ASSERT_IMPL(a_pad_zero, out_tvalid || in_seen,
                     !out_tvalid || (out_tdata[OUT_TDATA_W-1:CP_W] == '0))

  // input is only held off while the output register is full
  `U8DEC_ASSERT_IMPL(a_backpressure, !in_tready, out_tvalid)

  // with the output stalled, a full skid entry cannot drain
  `U8DEC_ASSERT_NEXT(a_skid_stays, !in_tready && !out_tready, !in_tready)

endmodule

bind utf8_to_codepoint_decoder_top u8dec_checker u_u8dec_checker (.*);

// ===== tb/utf8_to_codepoint_decoder_top_test.sv =====
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder_top_test
// Self-checking bench for the UTF-8 decoder. Byte beats go in with bursty
// gaps while the output side stalls on its own pattern. A scoreboard decodes
// every accepted byte and checks each output beat in order against it.
// ----------------------------------------------------------------------------
module utf8_to_codepoint_decoder_top_test;
  import u8dec_pkg::*;

  localparam int STALL_LIMIT   = 1000;  // cycles with no beat on either side
  localparam int HOLD_CYCLES   = 60;    // long output hold-off
  localparam int RANDOM_ITEMS  = 830;

  typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE, RX_PAIRS} rx_mode_t;

  // --------------------------------------------------------------------------
  // Expected code point store plus its own decoder
  // --------------------------------------------------------------------------
  class cp_scoreboard;
    typedef struct packed {
      logic [CP_W-1:0] cp;
      logic            ends;
    } cp_beat_t;

    logic [PEND_W-1:0] bytes_left;
    logic [CP_W-1:0]   accum;
    cp_beat_t          cp_queue[$];
    int                errors;

    function new();
      bytes_left = '0;
      accum      = '0;
      errors     = 0;
    endfunction

    function int outstanding();
      return cp_queue.size();
    endfunction

    function void report(string what, logic [OUT_TDATA_W-1:0] exp_d, logic exp_l,
                         logic [OUT_TDATA_W-1:0] got_d, logic got_l);
      errors++;
      if (errors <= 10)
        $display("mismatch (%s): expected cp=%06h last=%0b, got cp=%06h last=%0b",
                 what, exp_d, exp_l, got_d, got_l);
    endfunction

    // decode one accepted byte beat
    function void note_byte(logic [BYTE_W-1:0] b, logic last);
      cp_beat_t nb;
      logic     emit;
      emit  = 1'b0;
      nb.cp = '0;
      if (bytes_left != '0) begin
        // open sequence: any byte counts as a continuation
        accum      = {accum[CP_W-7:0], b[5:0]};
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == '0) begin
          emit  = 1'b1;
          nb.cp = accum;
        end
      end else begin
        casez (b)
          8'b0???????: begin
            emit  = 1'b1;
            nb.cp = CP_W'(b);
          end
          8'b110?????: begin
            accum      = CP_W'(b[4:0]);
            bytes_left = 2'd1;
          end
          8'b1110????: begin
            accum      = CP_W'(b[3:0]);
            bytes_left = 2'd2;
          end
          8'b11110???: begin
            accum      = CP_W'(b[2:0]);
            bytes_left = 2'd3;
          end
          default: ;  // stray continuation or bad lead: dropped
        endcase
      end
      // end of text: cut-off sequence gives '?', decoder starts over
      if (last) begin
        if (bytes_left != '0) begin
          emit  = 1'b1;
          nb.cp = QMARK_CP;
        end
        bytes_left = '0;
        accum      = '0;
      end
      nb.ends = last;
      if (emit) cp_queue = {cp_queue, nb};
    endfunction

    // compare one output beat with the oldest expected code point
    function void check_beat(logic [OUT_TDATA_W-1:0] d, logic last);
      cp_beat_t e;
      if (cp_queue.size() == 0) begin
        report("unexpected beat", '0, 1'b0, d, last);
        return;
      end
      e = cp_queue.pop_front();
      if (d !== OUT_TDATA_W'(e.cp)) report("code point", OUT_TDATA_W'(e.cp), e.ends, d, last);
      else if (last !== e.ends) report("ends text", OUT_TDATA_W'(e.cp), e.ends, d, last);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and signals
  // --------------------------------------------------------------------------
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  utf8_to_codepoint_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] text_byte
    .in_tlast   (in_tlast),   // final_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [20:0] code_point, rest zero
    .out_tlast  (out_tlast)   // ends_text
  );

  cp_scoreboard sb = new();

  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  bit          no_gaps    = 1'b0;
  bit          hold_req   = 1'b0;

  // {final_byte, text_byte}
  logic [8:0] directed_beats [26] = '{
    9'h000, 9'h07F,                    // ASCII extremes
    9'h0C2, 9'h0A9,                    // two-byte sequence
    9'h0E2, 9'h082, 9'h0AC,            // three-byte sequence
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,    // four-byte, all ones
    9'h080,                            // stray continuation
    9'h0FF, 9'h0F8,                    // bad leads
    9'h0E0, 9'h0C3, 9'h0FF,            // leads taken as continuations
    9'h1F0,                            // lead as final byte
    9'h0C3, 9'h1A9,                    // sequence completed by final byte
    9'h0E2, 9'h182,                    // text cut off mid-sequence
    9'h1BF,                            // dropped final byte
    9'h141,                            // ASCII final byte
    9'h0C0, 9'h080                     // overlong zero
  };

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0 || no_gaps) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(negedge clk);
    while (in_tready !== 1'b1) @(negedge clk);
    @(posedge clk);
    sb.note_byte(b, last);
    items_sent++;
    burst_left--;
  endtask

  function automatic logic [BYTE_W-1:0] lead_byte(int len);
    case (len)
      2:       return {3'b110, 5'($urandom)};
      3:       return {4'b1110, 4'($urandom)};
      default: return {5'b11110, 3'($urandom)};
    endcase
  endfunction

  // mostly well-formed continuations, now and then any byte
  function automatic logic [BYTE_W-1:0] cont_byte();
    if ($urandom_range(0, 19) == 0) return 8'($urandom);
    return {2'b10, 6'($urandom)};
  endfunction

  // one text: mixed sequences, some noise, sometimes cut off at the end
  task automatic send_random_text();
    logic [BYTE_W-1:0] txt[$];
    int                n_chars;
    int                kind;
    int                len;
    n_chars = $urandom_range(1, 10);
    for (int i = 0; i < n_chars; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        txt = {txt, {1'b0, 7'($urandom)}};
      end else if (kind < 88) begin
        len = (kind < 60) ? 2 : (kind < 75) ? 3 : 4;
        txt = {txt, lead_byte(len)};
        repeat (len - 1) txt = {txt, cont_byte()};
      end else if (kind < 92) begin
        txt = {txt, {2'b10, 6'($urandom)}};
      end else if (kind < 95) begin
        txt = {txt, {5'b11111, 3'($urandom)}};
      end else begin
        txt = {txt, 8'($urandom)};
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(2, 4);
      txt = {txt, lead_byte(len)};
      repeat ($urandom_range(0, len - 2)) txt = {txt, cont_byte()};
    end
    foreach (txt[k]) send_byte(txt[k], k == txt.size() - 1);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: own stall pattern plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    rx_mode_t    mode      = RX_OPEN;
    int unsigned mode_left = 0;
    int unsigned hold_left = 0;
    int unsigned tick      = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        hold_left  = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 100);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   out_tready <= 1'b1;
          RX_HALF:   out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          default:   out_tready <= tick[1];
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor
  // --------------------------------------------------------------------------
  initial begin
    logic [OUT_TDATA_W-1:0] d;
    logic                   l;
    forever begin
      @(negedge clk);
      if (rst_n && out_tvalid === 1'b1 && out_tready) begin
        d = out_tdata;
        l = out_tlast;
        @(posedge clk);
        sb.check_beat(d, l);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: no beat on either side for too long
  // --------------------------------------------------------------------------
  initial begin
    int unsigned quiet = 0;
    forever begin
      @(negedge clk);
      if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    bit hold_done  = 1'b0;
    bit pause_done = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corner cases
    foreach (directed_beats[i]) send_byte(directed_beats[i][7:0], directed_beats[i][8]);

    // random texts
    while (items_sent < RANDOM_ITEMS) begin
      send_random_text();
      if (!hold_done && items_sent >= 300) begin
        // output held off while ASCII keeps coming: output stage fills up
        hold_done = 1'b1;
        hold_req  = 1'b1;
        no_gaps   = 1'b1;
        repeat (40) send_byte({1'b0, 7'($urandom)}, $urandom_range(0, 7) == 0);
        send_byte({1'b0, 7'($urandom)}, 1'b1);
        no_gaps   = 1'b0;
      end
      if (!pause_done && items_sent >= 550) begin
        // sender waits for the pipe to drain
        pause_done = 1'b1;
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
        burst_left = 0;
      end
    end
    in_tvalid <= 1'b0;

    // drain and let any stray beat show up
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
